// ===== src/pcd_pkg.sv =====
// Package for the POCSAG codeword decoder: constants, types and helper functions.
// Used by the datapath, controller, top and both bench files; depends on nothing.
package pcd_pkg;

  localparam int unsigned MsgChars = 64;
  localparam int unsigned LenW = $clog2(MsgChars + 1);
  localparam int unsigned IdxW = (MsgChars > 1) ? $clog2(MsgChars) : 1;

  localparam logic [31:0] SyncWord = 32'h7CD215D8;
  localparam logic [31:0] IdleWord = 32'h7A89C197;
  localparam logic [31:0] MsgFlag  = 32'h80000000;
  localparam logic [17:0] AddrMask = 18'h3FFFF;
  localparam logic [19:0] DataMask = 20'hFFFFF;
  localparam logic [10:0] BchGen   = 11'h769;

  localparam logic [1:0] ModeData  = 2'd0;
  localparam logic [1:0] ModeTick  = 2'd1;
  localparam logic [1:0] ModeFlush = 2'd2;

  localparam logic RegNibbleReverse = 1'b0;
  localparam logic RegTimeout       = 1'b1;

  // Controller to datapath commands.
  typedef struct packed {
    logic shift_byte;   // shift input byte into window
    logic flush_hunt;   // clear window and hunt state
    logic chk_load;     // load codeword into the checker
    logic chk_flip;     // try next single-bit flip
    logic open_msg;     // open message from corrected address word
    logic app_nib;      // append nibble app_sel of the corrected word
    logic clr_idle;     // clear idle tick count
    logic tick;         // count one idle tick
    logic close_msg;    // close open message
    logic out_load;     // load output register with char at rd index minus one
    logic rd_inc;       // advance drain index
    logic rd_clr;       // restart drain index
    logic [2:0] app_sel;
  } pcd_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic word_done;    // a full codeword completed with the last byte
    logic chk_ok;       // current candidate passes
    logic chk_last;     // current candidate is the last flip
    logic is_idle;
    logic is_msg;
    logic msg_open;
    logic msg_full;
    logic msg_empty;
    logic timed_out;    // tick count reached timeout after increment
    logic rd_last;      // drain index has advanced past the last character
  } pcd_stat_t;

  function automatic logic [6:0] char_of(input logic [3:0] nib);
    logic [6:0] c;
    case (nib)
      4'hA, 4'hC: c = 7'h20;
      4'hB:       c = 7'h55;
      4'hD:       c = 7'h2D;
      4'hE:       c = 7'h28;
      4'hF:       c = 7'h29;
      default:    c = 7'h30 + {3'd0, nib};
    endcase
    return c;
  endfunction

  // Syndrome of bits 31..1 by g(x), 21 reduction steps over the full 31-bit word.
  function automatic logic [9:0] bch_rem(input logic [30:0] r);
    logic [30:0] x;
    x = r;
    for (int b = 30; b >= 10; b--) begin
      if (x[b]) x[b -: 11] = x[b -: 11] ^ BchGen;
    end
    return x[9:0];
  endfunction

endpackage

// ===== src/pcd_stream_if.sv =====
// Valid/ready channel carrying a generic payload.
// Depends on nothing.
interface pcd_stream_if #(parameter int unsigned W = 8);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/pcd_datapath.sv =====
// Datapath: sync window, BCH checker, message store and output register.
// Depends on pcd_pkg.
module pcd_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        byte_i,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  input  pcd_pkg::pcd_cmd_t cmd_i,
  output pcd_pkg::pcd_stat_t stat_o,
  output logic [36:0]       out_o
);
  logic [31:0] win_q;
  logic [2:0]  fill_q;
  logic        batch_q;
  logic [1:0]  bpos_q;
  logic [3:0]  slot_q, wslot_q;
  logic [31:0] cw_q;
  logic [5:0]  flip_q;
  logic        nrev_q;
  logic [15:0] tmo_q, idle_q;
  logic        open_q;
  logic [20:0] addr_q;
  logic [1:0]  func_q;
  logic [pcd_pkg::LenW-1:0] len_q, rd_q;
  logic [3:0]  mem [pcd_pkg::MsgChars];
  logic [3:0]  rdat_q;
  logic [31:0] cand, nw;
  logic [3:0]  nib, nibr;

  assign nw = {win_q[23:0], byte_i};
  // flip_q 0 is the word as received, 1..32 flip bit 0..31
  always_comb begin
    cand = cw_q;
    if (flip_q != 6'd0) cand = cw_q ^ (32'd1 << (flip_q[4:0] - 5'd1));
  end

  always_comb begin
    case (cmd_i.app_sel)
      3'd0: nib = cand[30:27];
      3'd1: nib = cand[26:23];
      3'd2: nib = cand[22:19];
      3'd3: nib = cand[18:15];
      default: nib = cand[14:11];
    endcase
    nibr = nrev_q ? {nib[0], nib[1], nib[2], nib[3]} : nib;
  end

  assign stat_o.word_done = batch_q && (bpos_q == 2'd3);
  assign stat_o.chk_ok = (pcd_pkg::bch_rem(cand[31:1]) == 10'd0) && !(^cand);
  assign stat_o.chk_last = (flip_q == 6'd32);
  assign stat_o.is_idle = (cand == pcd_pkg::IdleWord);
  assign stat_o.is_msg = (cand & pcd_pkg::MsgFlag) != 32'd0;
  assign stat_o.msg_open = open_q;
  assign stat_o.msg_full = (len_q >= pcd_pkg::LenW'(pcd_pkg::MsgChars));
  assign stat_o.msg_empty = (len_q == '0);
  assign stat_o.timed_out = ((idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1) >=
                            ((tmo_q == 16'd0) ? 16'd1 : tmo_q);
  assign stat_o.rd_last = (rd_q == len_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.app_nib && !stat_o.msg_full) mem[len_q[pcd_pkg::IdxW-1:0]] <= nibr;
    rdat_q <= mem[rd_q[pcd_pkg::IdxW-1:0]];
    if (cmd_i.chk_load) cw_q <= nw;
    if (cmd_i.out_load)
      out_o <= {addr_q, func_q, pcd_pkg::char_of(rdat_q), 6'(rd_q - 1'b1),
                stat_o.rd_last};
  end
  // out_load is issued in the cycle after rd_inc, so rd_q-1 is the index whose
  // data sits in rdat_q; the last char is the one where the advanced index
  // equals the length.

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0; fill_q <= '0; batch_q <= 1'b0; bpos_q <= '0; slot_q <= '0;
      wslot_q <= '0; flip_q <= '0; nrev_q <= 1'b0; tmo_q <= 16'd1000;
      idle_q <= '0; open_q <= 1'b0; addr_q <= '0; func_q <= '0; len_q <= '0;
      rd_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == pcd_pkg::RegNibbleReverse) nrev_q <= cfg_data_i[0];
        else tmo_q <= cfg_data_i;
      end
      if (cmd_i.shift_byte) begin
        win_q <= nw;
        if (!batch_q) begin
          if (fill_q < 3'd4) fill_q <= fill_q + 3'd1;
          if (fill_q >= 3'd3 && nw == pcd_pkg::SyncWord) begin
            batch_q <= 1'b1; bpos_q <= '0; slot_q <= '0;
          end
        end else begin
          bpos_q <= bpos_q + 2'd1;
          if (bpos_q == 2'd3) begin
            wslot_q <= slot_q;
            slot_q <= slot_q + 4'd1;
            if (slot_q == 4'd15) begin batch_q <= 1'b0; fill_q <= '0; end
          end
        end
      end
      if (cmd_i.flush_hunt) begin
        win_q <= '0; fill_q <= '0; batch_q <= 1'b0; bpos_q <= '0; slot_q <= '0;
      end
      if (cmd_i.chk_load) flip_q <= '0;
      if (cmd_i.chk_flip) flip_q <= flip_q + 6'd1;
      if (cmd_i.tick && idle_q != 16'hFFFF) idle_q <= idle_q + 16'd1;
      if (cmd_i.clr_idle) idle_q <= '0;
      if (cmd_i.app_nib && !stat_o.msg_full) len_q <= len_q + 1'b1;
      if (cmd_i.close_msg) begin
        open_q <= 1'b0; len_q <= '0; addr_q <= '0; func_q <= '0; idle_q <= '0;
      end
      if (cmd_i.open_msg) begin
        open_q <= 1'b1; len_q <= '0; idle_q <= '0;
        addr_q <= {cand[30:13] & pcd_pkg::AddrMask, wslot_q[3:1]};
        func_q <= cand[12:11];
      end
      if (cmd_i.rd_clr) rd_q <= '0;
      if (cmd_i.rd_inc) rd_q <= rd_q + 1'b1;
    end
  end
endmodule

// ===== src/pcd_ctrl.sv =====
// Controller: sequences byte handling, codeword correction, ticks, flushes and message drain.
// Depends on pcd_pkg.
module pcd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  pcd_pkg::pcd_stat_t stat_i,
  output pcd_pkg::pcd_cmd_t  cmd_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_ACT, S_APPEND, S_DRAIN_RD, S_DRAIN_LD, S_DRAIN_OUT,
    S_CLOSE, S_POST
  } state_e;
  state_e state_q;
  logic [2:0] sel_q;
  logic post_open_q;
  logic acc;

  assign in_ready_o = (state_q == S_IDLE);
  assign acc = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == S_DRAIN_OUT);

  always_comb begin
    cmd_o = '0;
    cmd_o.app_sel = sel_q;
    unique case (state_q)
      S_IDLE: if (acc && mode_i == pcd_pkg::ModeData) cmd_o.shift_byte = 1'b1;
        else if (acc && mode_i == pcd_pkg::ModeTick && stat_i.msg_open) cmd_o.tick = 1'b1;
      S_CHECK: if (!stat_i.chk_ok && !stat_i.chk_last) cmd_o.chk_flip = 1'b1;
      S_APPEND: if (!stat_i.msg_full) begin
          cmd_o.app_nib = 1'b1;
          if (sel_q == 3'd4) cmd_o.clr_idle = 1'b1;
        end
      S_DRAIN_RD: cmd_o.rd_inc = 1'b1;
      S_DRAIN_LD: cmd_o.out_load = 1'b1;
      S_DRAIN_OUT: ;
      S_CLOSE: begin cmd_o.close_msg = 1'b1; cmd_o.rd_clr = 1'b1; end
      S_POST: if (post_open_q) cmd_o.open_msg = 1'b1;
      default: ;
    endcase
    if (state_q == S_IDLE && acc && mode_i == pcd_pkg::ModeData && stat_i.word_done)
      cmd_o.chk_load = 1'b1;
    if (state_q == S_IDLE && acc && mode_i == pcd_pkg::ModeFlush)
      cmd_o.flush_hunt = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; sel_q <= '0; post_open_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: if (acc) begin
            post_open_q <= 1'b0;
            unique case (mode_i)
              pcd_pkg::ModeData: if (stat_i.word_done) state_q <= S_CHECK;
              pcd_pkg::ModeTick: if (stat_i.msg_open && stat_i.timed_out)
                  state_q <= stat_i.msg_empty ? S_CLOSE : S_DRAIN_RD;
              pcd_pkg::ModeFlush: state_q <= stat_i.msg_empty ? S_CLOSE : S_DRAIN_RD;
              default: ;
            endcase
          end
        S_CHECK: if (stat_i.chk_ok) state_q <= S_ACT;
          else if (stat_i.chk_last) state_q <= S_IDLE;
        S_ACT: if (stat_i.is_idle) begin
            state_q <= (stat_i.msg_open && !stat_i.msg_empty) ? S_DRAIN_RD : S_CLOSE;
          end else if (!stat_i.is_msg) begin
            post_open_q <= 1'b1;
            state_q <= (stat_i.msg_open && !stat_i.msg_empty) ? S_DRAIN_RD : S_CLOSE;
          end else if (stat_i.msg_open) begin
            sel_q <= '0; state_q <= S_APPEND;
          end else state_q <= S_IDLE;
        S_APPEND: if (stat_i.msg_full) state_q <= S_DRAIN_RD;
          else if (sel_q == 3'd4) state_q <= S_IDLE;
          else sel_q <= sel_q + 3'd1;
        S_DRAIN_RD: state_q <= S_DRAIN_LD;
        S_DRAIN_LD: state_q <= S_DRAIN_OUT;
        S_DRAIN_OUT: if (out_ready_i)
            state_q <= stat_i.rd_last ? S_CLOSE : S_DRAIN_RD;
        S_CLOSE: state_q <= S_POST;
        S_POST: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/pocsag_codeword_decoder_top.sv =====
// POCSAG codeword decoder: byte sync hunt, BCH(31,21) single-bit correction,
// numeric message assembly. A byte completing a codeword is checked, then with
// each single-bit flip in turn, decoded, its five nibbles appended if a
// message word; a message drains char by char via store read, output load and
// handshake (stalls on ready), then closes; no new item is taken until done.
// Async active-low reset; config resets to nibble reversal off, timeout 1000.
module pocsag_codeword_decoder_top (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  pcd_stream_if.sink   in_if,
  pcd_stream_if.source out_if
);
  pcd_pkg::pcd_cmd_t  cmd;
  pcd_pkg::pcd_stat_t stat;

  pcd_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .mode_i(in_if.data[9:8]),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .stat_i(stat), .cmd_o(cmd)
  );

  pcd_datapath u_dp (
    .clk_i, .rst_ni, .byte_i(in_if.data[7:0]),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_i(cmd), .stat_o(stat), .out_o(out_if.data)
  );
endmodule

// ===== bench/tb_pcd_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the POCSAG codeword decoder: watches config writes and both
// stream channels, predicts message characters and compares. Uses pcd_pkg and pcd_stream_if.
module tb_pcd_checker (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  pcd_stream_if in_if,
  pcd_stream_if out_if,
  output int fails_o,
  output int pending_o
);
  typedef struct packed {
    logic [20:0] address;
    logic [1:0]  function_code;
    logic [6:0]  character;
    logic [5:0]  char_index;
    logic        last_char;
  } page_char_t;

  page_char_t expected_chars[$];

  logic        rev_nib;
  logic [15:0] timeout_ticks;
  logic [31:0] window;
  int unsigned fill, byte_pos, slot, msg_len;
  logic        hunting_done, msg_open;
  logic [20:0] msg_addr;
  logic [1:0]  msg_func;
  logic [3:0]  nibs[64];
  logic [15:0] idle_cnt;
  int          mismatches;

  assign fails_o = mismatches;

  function automatic logic [6:0] ascii_of(input logic [3:0] n);
    case (n)
      4'hA, 4'hC: return 7'd32;
      4'hB: return 7'd85;
      4'hD: return 7'd45;
      4'hE: return 7'd40;
      4'hF: return 7'd41;
      default: return 7'd48 + {3'd0, n};
    endcase
  endfunction

  function automatic bit codeword_valid(input logic [31:0] w);
    logic [30:0] r;
    r = w[31:1];
    for (int b = 30; b >= 10; b--)
      if (r[b]) r = r ^ (31'h769 << (b - 10));
    return (r[9:0] == 0) && !(^w);
  endfunction

  task automatic emit_message();
    page_char_t c;
    if (msg_open && msg_len > 0) begin
      for (int k = 0; k < msg_len; k++) begin
        c.address = msg_addr;
        c.function_code = msg_func;
        c.character = ascii_of(nibs[k]);
        c.char_index = k[5:0];
        c.last_char = (k + 1 == msg_len);
        expected_chars.push_back(c);
      end
    end
    msg_open = 0;
    msg_len = 0;
    msg_addr = '0;
    msg_func = '0;
    idle_cnt = '0;
  endtask

  task automatic decode_codeword(input logic [31:0] w, input int unsigned s);
    logic [31:0] f;
    logic [19:0] payload;
    logic [3:0]  n;
    bit          ok;
    ok = 0;
    if (codeword_valid(w)) begin
      ok = 1;
      f = w;
    end else begin
      for (int b = 0; b < 32 && !ok; b++) begin
        if (codeword_valid(w ^ (32'd1 << b))) begin
          ok = 1;
          f = w ^ (32'd1 << b);
        end
      end
    end
    if (!ok) return;
    if (f == pcd_pkg::IdleWord) begin
      emit_message();
    end else if (!f[31]) begin
      emit_message();
      msg_addr = {f[30:13], s[3:1]};
      msg_func = f[12:11];
      msg_open = 1;
    end else if (msg_open) begin
      payload = f[30:11];
      for (int i = 0; i < 5; i++) begin
        n = payload[19 - 4 * i -: 4];
        if (rev_nib) n = {n[0], n[1], n[2], n[3]};
        if (msg_len >= pcd_pkg::MsgChars) begin
          emit_message();
          return;
        end
        nibs[msg_len] = n;
        msg_len++;
      end
      idle_cnt = '0;
    end
  endtask

  task automatic predict_item(input logic [1:0] mode, input logic [7:0] data);
    case (mode)
      pcd_pkg::ModeData: begin
        window = {window[23:0], data};
        if (!hunting_done) begin
          if (fill < 4) fill++;
          if (fill >= 4 && window == pcd_pkg::SyncWord) begin
            hunting_done = 1;
            byte_pos = 0;
            slot = 0;
          end
        end else begin
          byte_pos = (byte_pos + 1) % 4;
          if (byte_pos == 0) begin
            decode_codeword(window, slot);
            slot = (slot + 1) % 16;
            if (slot == 0) begin
              hunting_done = 0;
              fill = 0;
            end
          end
        end
      end
      pcd_pkg::ModeTick: begin
        if (msg_open) begin
          if (idle_cnt != 16'hFFFF) idle_cnt++;
          if (idle_cnt >= timeout_ticks) emit_message();
        end
      end
      pcd_pkg::ModeFlush: begin
        emit_message();
        window = '0;
        fill = 0;
        hunting_done = 0;
        byte_pos = 0;
        slot = 0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    page_char_t got, want;
    if (!rst_ni) begin
      rev_nib = 0;
      timeout_ticks = 16'd1000;
      window = '0;
      fill = 0;
      byte_pos = 0;
      slot = 0;
      hunting_done = 0;
      msg_open = 0;
      msg_len = 0;
      msg_addr = '0;
      msg_func = '0;
      idle_cnt = '0;
      mismatches = 0;
      expected_chars.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == pcd_pkg::RegNibbleReverse) rev_nib = cfg_data_i[0];
        else timeout_ticks = cfg_data_i;
      end
      if (in_if.valid && in_if.ready) predict_item(in_if.data[9:8], in_if.data[7:0]);
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (expected_chars.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected char transfer %h", got);
        end else begin
          want = expected_chars.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("char mismatch: exp addr %h fn %0d ch %h idx %0d last %0d",
                       want.address, want.function_code, want.character,
                       want.char_index, want.last_char);
              $display("               got addr %h fn %0d ch %h idx %0d last %0d",
                       got.address, got.function_code, got.character,
                       got.char_index, got.last_char);
            end
          end
        end
      end
    end
    pending_o = expected_chars.size();
  end

endmodule

// ===== bench/tb_pocsag_codeword_decoder_top.sv =====
`timescale 1ns / 100ps
// Top of the POCSAG decoder bench: clock, reset, byte/tick/flush stimulus with
// random idling, config phases and verdict. Uses pcd_pkg, pcd_stream_if, tb_pcd_checker.
module tb_pocsag_codeword_decoder_top;
  localparam logic [1:0] ModeIgnored = 2'd3;
  localparam int StallLimit = 20000;

  logic clk_i, rst_ni, cfg_we_i, cfg_idx_i;
  logic [15:0] cfg_data_i;
  int fails, pending, quiet_cycles;
  int src_idle_pct, rcv_stall_pct;
  logic hold_rcv;

  pcd_stream_if #(.W(10)) in_if ();
  pcd_stream_if #(.W(37)) out_if ();

  pocsag_codeword_decoder_top u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_if(in_if.sink), .out_if(out_if.source)
  );

  tb_pcd_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_if(in_if), .out_if(out_if), .fails_o(fails), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i)
    out_if.ready <= !hold_rcv && ($urandom_range(0, 99) >= rcv_stall_pct);

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] bch_encode(input logic [20:0] d);
    logic [30:0] r;
    logic [31:0] w;
    r = {d, 10'd0};
    for (int b = 30; b >= 10; b--)
      if (r[b]) r = r ^ (31'h769 << (b - 10));
    w = {d, r[9:0], 1'b0};
    w[0] = ^w;
    return w;
  endfunction

  // valid stays high across back-to-back transfers; push_item drops it only for a gap
  task automatic push_item(input logic [1:0] mode, input logic [7:0] data);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 0;
      while ($urandom_range(0, 99) < src_idle_pct) @(posedge clk_i);
      @(posedge clk_i);
    end
    in_if.valid <= 1;
    in_if.data <= {mode, data};
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) push_item(pcd_pkg::ModeData, w[8 * i +: 8]);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic settle();
    in_if.valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // one batch: sync then up to 16 codewords; long_msg sends an address then only message words, to overflow
  task automatic push_batch(input int words, input bit long_msg);
    logic [31:0] w;
    int pick;
    push_word(pcd_pkg::SyncWord);
    for (int s = 0; s < words; s++) begin
      pick = $urandom_range(0, 99);
      if (long_msg) w = (s == 0) ? bch_encode({1'b0, 20'($urandom)})
                                 : bch_encode({1'b1, 20'($urandom)});
      else if (pick < 22) w = bch_encode({1'b0, 20'($urandom)});
      else if (pick < 82) w = bch_encode({1'b1, 20'($urandom)});
      else if (pick < 94) w = pcd_pkg::IdleWord;
      else w = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 15) w[$urandom_range(0, 31)] ^= 1'b1;
      else if (pick < 20) w ^= (32'd3 << $urandom_range(0, 30));
      push_word(w);
      if ($urandom_range(0, 9) == 0) push_item(pcd_pkg::ModeTick, 8'($urandom));
    end
    if (words < 16) push_item(pcd_pkg::ModeFlush, 8'($urandom));
  endtask

  initial begin
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_idx_i = 0;
    cfg_data_i = '0;
    in_if.valid = 0;
    in_if.data = '0;
    out_if.ready = 0;
    hold_rcv = 0;
    quiet_cycles = 0;
    src_idle_pct = 0;
    rcv_stall_pct = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: ignored mode, tick and flush with nothing open, noise, near-sync,
    // then a short message with corrected bit errors closed by tick timeout
    write_reg(pcd_pkg::RegNibbleReverse, 16'd0);
    write_reg(pcd_pkg::RegTimeout, 16'd2);
    push_item(ModeIgnored, 8'hFF);
    push_item(pcd_pkg::ModeTick, 8'h00);
    push_item(pcd_pkg::ModeFlush, 8'hAA);
    push_item(pcd_pkg::ModeData, 8'h7C);
    push_item(pcd_pkg::ModeData, 8'hD2);
    push_item(pcd_pkg::ModeData, 8'h15);
    push_item(pcd_pkg::ModeData, 8'hD9);
    push_item(pcd_pkg::ModeData, 8'h00);
    push_word(pcd_pkg::SyncWord);
    push_word(bch_encode({1'b1, 20'hABCDE}));
    push_word(bch_encode({1'b0, 20'hFFFFF}) ^ 32'h8000_0000);
    push_word(bch_encode({1'b1, 20'h01234}) ^ 32'h1);
    push_item(pcd_pkg::ModeTick, 8'h00);
    push_item(pcd_pkg::ModeTick, 8'h00);
    push_item(pcd_pkg::ModeFlush, 8'h00);
    settle();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin src_idle_pct = 59; rcv_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  rcv_stall_pct = 59; end
        3: begin src_idle_pct = 16; rcv_stall_pct = 16; end
        default: begin src_idle_pct = 0; rcv_stall_pct = 10; end
      endcase
      write_reg(pcd_pkg::RegNibbleReverse, 16'(ph % 2));
      write_reg(pcd_pkg::RegTimeout,
                (ph == 2) ? 16'hFFFF : (ph == 0) ? 16'd1 : 16'($urandom_range(1, 4)));
      if (ph == 4) begin
        fork
          begin
            hold_rcv <= 1;
            repeat (1500) @(posedge clk_i);
            hold_rcv <= 0;
          end
        join_none
        push_batch(16, 1);
      end else begin
        push_batch($urandom_range(2, 5), 0);
        repeat ($urandom_range(1, 5)) push_item(pcd_pkg::ModeTick, 8'($urandom));
      end
      push_item(pcd_pkg::ModeFlush, 8'($urandom));
      settle();
    end

    if (fails == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/pcd_pkg.sv
src/pcd_stream_if.sv
src/pcd_datapath.sv
src/pcd_ctrl.sv
src/pocsag_codeword_decoder_top.sv
bench/tb_pcd_checker.sv
bench/tb_pocsag_codeword_decoder_top.sv
